// File: hw/rtl/ssfp_pkg.sv
// ----------------------------------------------------------------------------
// ssfp_pkg
// Shared constants, types and the gap compare helper for the spectrum slot
// fit and place pipeline.
// ----------------------------------------------------------------------------
package ssfp_pkg;

	localparam int SLOT_COUNT    = 40;
	localparam int MASK_W        = 40;
	localparam int FIELD_W       = 6;
	localparam int CFG_W         = 6;
	localparam int THR_W         = CFG_W + 1;
	localparam int USEFUL_MARGIN = 5;
	localparam int CFG_RESET     = 40;
	localparam int FIT_W         = 2;

	localparam int RUN_W      = $clog2(SLOT_COUNT + 1);
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int RUN_LVL    = $clog2(SLOT_COUNT);
	localparam int RUN_LVL_A  = RUN_LVL / 2;
	localparam int TREE_LVL_A = RUN_LVL / 2;
	localparam int TREE_N_B   = (SLOT_COUNT + (1 << TREE_LVL_A) - 1) >> TREE_LVL_A;
	localparam int TREE_LVL_B = $clog2(TREE_N_B);

	localparam int IN_BITS  = MASK_W + 2 * FIELD_W + 2;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = FIT_W + 1 + 2 * FIELD_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [FIT_W-1:0] FIT_IN_PLACE = 2'd0;
	localparam logic [FIT_W-1:0] FIT_MOVED    = 2'd1;
	localparam logic [FIT_W-1:0] FIT_NONE     = 2'd2;

	typedef struct packed {
		logic [MASK_W-1:0]  mask;
		logic [FIELD_W-1:0] left;
		logic [FIELD_W-1:0] right;
		logic               rev;
		logic               alr;
	} in_item_t;

	typedef struct packed {
		logic               ok;
		logic               inplace;
		logic               rev;
		logic               alr;
		logic [FIELD_W-1:0] left;
		logic [FIELD_W-1:0] right;
		logic [RUN_W-1:0]   w;
	} req_t;

	typedef struct packed {
		req_t                              req;
		logic [SLOT_COUNT-1:0]             st;
		logic [SLOT_COUNT-1:0][RUN_W-1:0]  gw;
	} scan_t;

	typedef struct packed {
		logic             vld;
		logic [RUN_W-1:0] pen;
		logic [IDX_W-1:0] idx;
		logic [RUN_W-1:0] gw;
	} node_t;

	typedef struct packed {
		logic [FIT_W-1:0]   fit;
		logic               rev;
		logic               alr;
		logic [FIELD_W-1:0] left;
		logic [FIELD_W-1:0] right;
		logic [RUN_W-1:0]   w;
	} sel_ctl_t;

	typedef struct packed {
		sel_ctl_t                   ctl;
		node_t [SLOT_COUNT-1:0]     node;
	} score_t;

	typedef struct packed {
		logic [FIT_W-1:0]   fit;
		logic               found;
		logic [FIELD_W-1:0] pl;
		logic [FIELD_W-1:0] pr;
	} res_t;

	// lo is the lower slot; hi wins a tie when searching downward
	function automatic node_t pick_node(node_t lo, node_t hi, logic rev);
		node_t r;
		r = lo;
		if (!lo.vld) begin
			r = hi;
		end else if (hi.vld && ((rev && hi.pen <= lo.pen) || (!rev && hi.pen < lo.pen))) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/ssfp_gap_scan.sv
// ----------------------------------------------------------------------------
// ssfp_gap_scan
// Request decode, in-place check and free run lengths by doubling, two stages.
// ----------------------------------------------------------------------------
module ssfp_gap_scan import ssfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output scan_t    out_data
);

	logic                             vld_s1, vld_s2;
	logic                             en_s1, en_s2;
	req_t                             req_c, req_s1, req_s2;
	logic [SLOT_COUNT-1:0]            free_c, st_c, st_s1, st_s2;
	logic [SLOT_COUNT-1:0][RUN_W-1:0] run_a_c, run_s1, run_b_c, gw_s2;

	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// decode and first run length levels
	always_comb begin
		logic                             busy_in;
		logic [SLOT_COUNT-1:0][RUN_W-1:0] nb;
		free_c  = ~SLOT_COUNT'(in_data.mask);
		st_c    = free_c & ~{free_c[SLOT_COUNT-2:0], 1'b0};
		busy_in = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (RUN_W'(in_data.left) <= RUN_W'(i + 1) && RUN_W'(in_data.right) >= RUN_W'(i + 1)
					&& !free_c[i]) begin
				busy_in = 1'b1;
			end
		end
		req_c.ok      = (in_data.left != '0) && (in_data.right >= in_data.left)
			&& (RUN_W'(in_data.right) <= RUN_W'(SLOT_COUNT));
		req_c.inplace = !busy_in;
		req_c.rev     = in_data.rev;
		req_c.alr     = in_data.alr;
		req_c.left    = in_data.left;
		req_c.right   = in_data.right;
		req_c.w       = RUN_W'(in_data.right) - RUN_W'(in_data.left) + RUN_W'(1);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			run_a_c[i] = RUN_W'(free_c[i]);
		end
		for (int k = 0; k < RUN_LVL_A; k++) begin
			nb = run_a_c >> (RUN_W * (1 << k));
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (run_a_c[i] == RUN_W'(1 << k)) begin
					run_a_c[i] = RUN_W'(1 << k) + nb[i];
				end
			end
		end
	end

	// remaining run length levels
	always_comb begin
		logic [SLOT_COUNT-1:0][RUN_W-1:0] nb;
		run_b_c = run_s1;
		for (int k = RUN_LVL_A; k < RUN_LVL; k++) begin
			nb = run_b_c >> (RUN_W * (1 << k));
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (run_b_c[i] == RUN_W'(1 << k)) begin
					run_b_c[i] = RUN_W'(1 << k) + nb[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			req_s1 <= req_c;
			st_s1  <= st_c;
			run_s1 <= run_a_c;
		end
		if (en_s2 && vld_s1) begin
			req_s2 <= req_s1;
			st_s2  <= st_s1;
			gw_s2  <= run_b_c;
		end
	end

	assign out_valid    = vld_s2;
	assign out_data.req = req_s2;
	assign out_data.st  = st_s2;
	assign out_data.gw  = gw_s2;

endmodule

// File: hw/rtl/ssfp_score.sv
// ----------------------------------------------------------------------------
// ssfp_score
// Per gap candidate flag, usefulness penalty and fit classification.
// ----------------------------------------------------------------------------
module ssfp_score import ssfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] min_width,
	input  logic             in_valid,
	output logic             in_ready,
	input  scan_t            in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output score_t           out_data
);

	logic             vld_s3;
	logic             en_s3;
	logic [THR_W-1:0] thr;
	score_t           score_c, score_s3;

	assign en_s3    = !vld_s3 || out_ready;
	assign in_ready = en_s3;
	assign thr      = THR_W'(min_width) + THR_W'(USEFUL_MARGIN);

	always_comb begin
		logic             any;
		logic [RUN_W-1:0] sur;
		logic             big;
		any = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			sur = in_data.gw[i] - in_data.req.w;
			big = in_data.gw[i] > thr;
			score_c.node[i].vld = in_data.req.ok && in_data.st[i]
				&& (in_data.gw[i] >= in_data.req.w);
			score_c.node[i].idx = IDX_W'(i);
			score_c.node[i].gw  = in_data.gw[i];
			if (!big) begin
				score_c.node[i].pen = '0;
			end else if (sur > thr) begin
				score_c.node[i].pen = in_data.req.w;
			end else begin
				score_c.node[i].pen = in_data.gw[i];
			end
			any = any | score_c.node[i].vld;
		end
		priority if (!in_data.req.ok) begin
			score_c.ctl.fit = FIT_NONE;
		end else if (in_data.req.inplace) begin
			score_c.ctl.fit = FIT_IN_PLACE;
		end else if (any) begin
			score_c.ctl.fit = FIT_MOVED;
		end else begin
			score_c.ctl.fit = FIT_NONE;
		end
		score_c.ctl.rev   = in_data.req.rev;
		score_c.ctl.alr   = in_data.req.alr;
		score_c.ctl.left  = in_data.req.left;
		score_c.ctl.right = in_data.req.right;
		score_c.ctl.w     = in_data.req.w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en_s3) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			score_s3 <= score_c;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = score_s3;

endmodule

// File: hw/rtl/ssfp_select.sv
// ----------------------------------------------------------------------------
// ssfp_select
// Registered best gap tree in two stages and final range placement.
// ----------------------------------------------------------------------------
module ssfp_select import ssfp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  score_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   out_data
);

	logic                     vld_s4, vld_s5, vld_s6;
	logic                     en_s4, en_s5, en_s6;
	sel_ctl_t                 ctl_s4, ctl_s5;
	node_t [TREE_N_B-1:0]     node_c, node_s4;
	node_t                    root_c, root_s5;
	res_t                     res_c, res_s6;

	assign en_s6    = !vld_s6 || out_ready;
	assign en_s5    = !vld_s5 || en_s6;
	assign en_s4    = !vld_s4 || en_s5;
	assign in_ready = en_s4;

	// first tree levels
	always_comb begin
		node_t [SLOT_COUNT:0] cur;
		cur = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			cur[i] = in_data.node[i];
		end
		for (int lv = 0; lv < TREE_LVL_A; lv++) begin
			for (int p = 0; p < (SLOT_COUNT + 1) / 2; p++) begin
				if (2 * p + 1 < ((SLOT_COUNT + (1 << lv) - 1) >> lv)) begin
					cur[p] = pick_node(cur[2 * p], cur[2 * p + 1], in_data.ctl.rev);
				end else if (2 * p < ((SLOT_COUNT + (1 << lv) - 1) >> lv)) begin
					cur[p] = cur[2 * p];
				end else begin
					cur[p] = '0;
				end
			end
		end
		for (int i = 0; i < TREE_N_B; i++) begin
			node_c[i] = cur[i];
		end
	end

	// remaining tree levels
	always_comb begin
		node_t [TREE_N_B:0] cur;
		cur = '0;
		for (int i = 0; i < TREE_N_B; i++) begin
			cur[i] = node_s4[i];
		end
		for (int lv = 0; lv < TREE_LVL_B; lv++) begin
			for (int p = 0; p < (TREE_N_B + 1) / 2; p++) begin
				if (2 * p + 1 < ((TREE_N_B + (1 << lv) - 1) >> lv)) begin
					cur[p] = pick_node(cur[2 * p], cur[2 * p + 1], ctl_s4.rev);
				end else if (2 * p < ((TREE_N_B + (1 << lv) - 1) >> lv)) begin
					cur[p] = cur[2 * p];
				end else begin
					cur[p] = '0;
				end
			end
		end
		root_c = cur[0];
	end

	// place the range inside the chosen gap
	always_comb begin
		logic [RUN_W-1:0] end1;
		end1         = RUN_W'(root_s5.idx) + root_s5.gw;
		res_c.fit    = ctl_s5.fit;
		res_c.found  = root_s5.vld;
		if (!root_s5.vld) begin
			res_c.pl = ctl_s5.left;
			res_c.pr = ctl_s5.right;
		end else if (ctl_s5.alr) begin
			res_c.pr = FIELD_W'(end1);
			res_c.pl = FIELD_W'(end1 - ctl_s5.w + RUN_W'(1));
		end else begin
			res_c.pl = FIELD_W'(RUN_W'(root_s5.idx) + RUN_W'(1));
			res_c.pr = FIELD_W'(RUN_W'(root_s5.idx) + ctl_s5.w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s4) begin
				vld_s4 <= in_valid;
			end
			if (en_s5) begin
				vld_s5 <= vld_s4;
			end
			if (en_s6) begin
				vld_s6 <= vld_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			ctl_s4  <= in_data.ctl;
			node_s4 <= node_c;
		end
		if (en_s5 && vld_s4) begin
			ctl_s5  <= ctl_s4;
			root_s5 <= root_c;
		end
		if (en_s6 && vld_s5) begin
			res_s6 <= res_c;
		end
	end

	assign out_valid = vld_s6;
	assign out_data  = res_s6;

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && res_s6.fit == FIT_MOVED |-> res_s6.found)
		else $error("moved request without a chosen gap");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && res_s6.fit == FIT_NONE |-> !res_s6.found)
		else $error("gap chosen for a request that cannot fit");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && res_s6.found |-> res_s6.pr >= res_s6.pl && res_s6.pl != '0)
		else $error("placed range out of order");

endmodule

// File: hw/rtl/spectrum_slot_fit_and_place.sv
// ----------------------------------------------------------------------------
// spectrum_slot_fit_and_place
// Contiguous spectrum slot best fit: classifies a requested slot range against
// a link occupancy mask and places it into the best free gap.
//
// Input stream s_axis carries one request per transaction: occupancy mask,
// requested range and the search direction and alignment bits. Output stream
// m_axis returns one result per request: fit code, gap found flag and the
// placed range. cfg writes the minimum request width that sets the useful
// gap threshold; write it only while no request is in flight.
// Each request passes through six pipeline stages
// (decode and run lengths, run lengths, scoring, two gap tree stages, placing).
// A new request is taken every cycle unless m_axis stalls with all stages full.
// Each stage holds its item while the stage ahead is full, so a stall on m_axis
// backs up stage by stage and s_axis_tready drops only once all six stages hold a result.
// Reset empties the pipeline and sets the minimum request width to 40.
// ----------------------------------------------------------------------------
module spectrum_slot_fit_and_place import ssfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // occupancy_mask, range_left, range_right,
	                                        // reverse_order, align_right, zero pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // fit_code, gap_found, placed_left,
	                                        // placed_right, zero pad
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] min_width_q;
	in_item_t         in_item;
	logic             scan_valid, scan_ready;
	scan_t            scan_data;
	logic             score_valid, score_ready;
	score_t           score_data;
	res_t             res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q <= CFG_W'(CFG_RESET);
		end else if (cfg_valid) begin
			min_width_q <= cfg_data;
		end
	end

	assign in_item.mask  = s_axis_tdata[MASK_W-1:0];
	assign in_item.left  = s_axis_tdata[MASK_W +: FIELD_W];
	assign in_item.right = s_axis_tdata[MASK_W + FIELD_W +: FIELD_W];
	assign in_item.rev   = s_axis_tdata[MASK_W + 2 * FIELD_W];
	assign in_item.alr   = s_axis_tdata[MASK_W + 2 * FIELD_W + 1];

	ssfp_gap_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (in_item),
		.out_valid (scan_valid),
		.out_ready (scan_ready),
		.out_data  (scan_data)
	);

	ssfp_score u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_width (min_width_q),
		.in_valid  (scan_valid),
		.in_ready  (scan_ready),
		.in_data   (scan_data),
		.out_valid (score_valid),
		.out_ready (score_ready),
		.out_data  (score_data)
	);

	ssfp_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (score_valid),
		.in_ready  (score_ready),
		.in_data   (score_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = OUT_W'({res.pr, res.pl, res.found, res.fit});

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled while the output holds no result");

endmodule

// File: sim/tb_spectrum_slot_fit_and_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_slot_fit_and_place
// Self-checking bench for the spectrum slot best fit classifier and placer.
//
// A clocked driver offers requests from a pending queue in random bursts. A
// clocked monitor predicts each accepted request and checks every returned
// result, in order, field by field. The receiver stalls on its own pattern
// and twice holds off long enough to back up the pipeline. Between phases the
// bench drains and rewrites the minimum request width.
// ----------------------------------------------------------------------------
module tb_spectrum_slot_fit_and_place;
	import ssfp_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD  = 80;
	localparam int PHASE_ITEMS = 130;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;   // occupancy_mask, range_left, range_right,
	                                  // reverse_order, align_right, zero pad
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;   // fit_code, gap_found, placed_left,
	                                  // placed_right, zero pad
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	in_item_t    request_q[$];
	res_t        placement_q[$];
	int unsigned min_width_shadow;
	int          mismatch_count;
	logic        in_fire;
	int          hold_asked;

	spectrum_slot_fit_and_place i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	function automatic res_t best_fit_place(in_item_t q, int unsigned min_w);
		res_t        r;
		int unsigned w, thr, useful, occupied, gw, surplus, score, best, ng, run_start;
		int unsigned gap_lo[SLOT_COUNT];
		int unsigned gap_hi[SLOT_COUNT];
		int unsigned pick, g, pl, pr;
		int          i, k;
		logic        fits_here, busy, in_run, have;
		r.fit   = FIT_NONE;
		r.found = 1'b0;
		r.pl    = q.left;
		r.pr    = q.right;
		if (q.left != 0 && q.right >= q.left && q.right <= SLOT_COUNT) begin
			w         = q.right - q.left + 1;
			thr       = min_w + USEFUL_MARGIN;
			fits_here = 1'b1;
			useful    = 0;
			occupied  = 0;
			ng        = 0;
			in_run    = 1'b0;
			run_start = 0;
			for (i = int'(q.left) - 1; i < int'(q.right); i++) begin
				if (q.mask[i]) begin
					fits_here = 1'b0;
				end
			end
			// the slot past the end acts as busy so a gap reaching the last slot closes
			for (i = 0; i <= SLOT_COUNT; i++) begin
				busy = (i == SLOT_COUNT) ? 1'b1 : q.mask[i];
				if (!busy && !in_run) begin
					in_run    = 1'b1;
					run_start = i;
				end else if (busy && in_run) begin
					in_run = 1'b0;
					gw     = i - run_start;
					if (gw >= w) begin
						gap_lo[ng] = run_start;
						gap_hi[ng] = i - 1;
						ng++;
					end
					if (gw > thr) begin
						useful += gw;
					end
				end
				if (i < SLOT_COUNT && busy) begin
					occupied++;
				end
			end
			r.fit = fits_here ? FIT_IN_PLACE : (ng > 0 ? FIT_MOVED : FIT_NONE);
			best  = 0;
			pick  = 0;
			have  = 1'b0;
			for (k = 0; k < int'(ng); k++) begin
				g       = q.rev ? ng - 1 - k : k;
				gw      = gap_hi[g] - gap_lo[g] + 1;
				surplus = gw - w;
				score   = useful;
				if (gw > thr) begin
					score -= gw;
				end
				if (surplus > thr) begin
					score += surplus;
				end
				score += occupied + w;
				if (score > best) begin
					best = score;
					pick = g;
					have = 1'b1;
				end
			end
			if (have) begin
				r.found = 1'b1;
				if (q.alr) begin
					pr = gap_hi[pick] + 1;
					pl = pr - w + 1;
				end else begin
					pl = gap_lo[pick] + 1;
					pr = pl + w - 1;
				end
				r.pl = FIELD_W'(pl);
				r.pr = FIELD_W'(pr);
			end
		end
		return r;
	endfunction

	task automatic add_request(input logic [MASK_W-1:0] mask, input int left, input int right,
		input logic rev, input logic alr);
		in_item_t q;
		q.mask  = mask;
		q.left  = FIELD_W'(left);
		q.right = FIELD_W'(right);
		q.rev   = rev;
		q.alr   = alr;
		request_q = {request_q, q};
	endtask

	task automatic add_random_requests(input int count);
		logic [MASK_W-1:0] mask;
		int                n, j, h, style, shape, w, left, right, start, len, holes;
		for (n = 0; n < count; n++) begin
			style = $urandom_range(0, 9);
			if (style <= 3) begin
				mask[31:0]       = $urandom;
				mask[MASK_W-1:32] = (MASK_W - 32)'($urandom_range(0, 255));
			end else if (style <= 6) begin
				mask  = '1;
				holes = $urandom_range(1, 4);
				for (h = 0; h < holes; h++) begin
					start = $urandom_range(0, SLOT_COUNT - 1);
					len   = $urandom_range(1, 16);
					for (j = start; j < start + len && j < SLOT_COUNT; j++) begin
						mask[j] = 1'b0;
					end
				end
			end else if (style <= 8) begin
				mask  = '0;
				holes = $urandom_range(0, 5);
				for (h = 0; h < holes; h++) begin
					mask[$urandom_range(0, SLOT_COUNT - 1)] = 1'b1;
				end
			end else begin
				mask = $urandom_range(0, 1) ? '1 : '0;
				mask[$urandom_range(0, SLOT_COUNT - 1)] = ~mask[0];
			end
			shape = $urandom_range(0, 19);
			if (shape == 0) begin
				left  = $urandom_range(0, 63);
				right = $urandom_range(0, 63);
			end else begin
				w     = (shape < 15) ? $urandom_range(1, 10) : $urandom_range(1, SLOT_COUNT);
				left  = $urandom_range(1, SLOT_COUNT + 1 - w);
				right = left + w - 1;
			end
			add_request(mask, left, right, 1'($urandom_range(0, 1)),
			            1'($urandom_range(0, 1)));
		end
	endtask

	task automatic write_min_width(input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		min_width_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		while (request_q.size() != 0 || placement_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (s_axis_tvalid && !in_fire) begin
			s_axis_tvalid <= 1'b1;
		end else if (gap_left > 0) begin
			s_axis_tvalid <= 1'b0;
			gap_left--;
		end else if (request_q.size() != 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= IN_W'({request_q[0].alr, request_q[0].rev, request_q[0].right,
			                        request_q[0].left, request_q[0].mask});
			if (burst_left <= 1) begin
				burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
				                                       : $urandom_range(1, 12);
				gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// receiver: stall pattern of its own, plus long hold-offs on request
	int   hold_count  = 0;
	int   hold_served = 0;
	int   mode_left   = 0;
	int   ready_mode  = 0;

	always @(negedge clk) begin
		if (hold_count > 0) begin
			m_axis_tready <= 1'b0;
			hold_count--;
		end else if (hold_served != hold_asked) begin
			m_axis_tready <= 1'b0;
			hold_count = LONG_HOLD - 1;
			hold_served++;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 150);
			end
			mode_left--;
			unique case (ready_mode)
				0: begin
					m_axis_tready <= 1'b1;
				end
				1: begin
					m_axis_tready <= 1'($urandom_range(0, 1));
				end
				2: begin
					m_axis_tready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					m_axis_tready <= (mode_left % 5) != 0;
				end
			endcase
		end
	end

	// monitor: predict accepted requests, check returned results in order
	always @(posedge clk) begin : monitor
		res_t got, want, pred;
		in_fire = s_axis_tvalid && s_axis_tready;
		if (in_fire) begin
			pred        = best_fit_place(request_q.pop_front(), min_width_shadow);
			placement_q = {placement_q, pred};
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.fit   = m_axis_tdata[1:0];
			got.found = m_axis_tdata[2];
			got.pl    = m_axis_tdata[8:3];
			got.pr    = m_axis_tdata[14:9];
			if (placement_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = placement_q.pop_front();
				if (got.fit != want.fit) begin
					$display("%0t: fit_code expected %0d actual %0d", $time, want.fit, got.fit);
					mismatch_count++;
				end
				if (got.found != want.found) begin
					$display("%0t: gap_found expected %0d actual %0d", $time, want.found,
					         got.found);
					mismatch_count++;
				end
				if (got.pl != want.pl) begin
					$display("%0t: placed_left expected %0d actual %0d", $time, want.pl, got.pl);
					mismatch_count++;
				end
				if (got.pr != want.pr) begin
					$display("%0t: placed_right expected %0d actual %0d", $time, want.pr,
					         got.pr);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
		    || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	localparam logic [MASK_W-1:0] TWIN_GAPS = 40'hFF_FFFF_F820;

	initial begin
		arst_n           = 1'b0;
		s_axis_tvalid    = 1'b0;
		s_axis_tdata     = '0;
		m_axis_tready    = 1'b0;
		cfg_valid        = 1'b0;
		cfg_data         = '0;
		in_fire          = 1'b0;
		hold_asked       = 0;
		mismatch_count   = 0;
		min_width_shadow = CFG_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed requests at the reset threshold
		add_request('0, 1, SLOT_COUNT, 1'b0, 1'b0);
		add_request('1, 1, 1, 1'b0, 1'b0);
		add_request(40'h7F_FFFF_FFFF, SLOT_COUNT, SLOT_COUNT, 1'b1, 1'b1);
		add_request(40'h7F_FFFF_FFFF, 1, 1, 1'b0, 1'b0);
		add_request(TWIN_GAPS, 20, 22, 1'b0, 1'b0);
		add_request(TWIN_GAPS, 20, 22, 1'b1, 1'b0);
		add_request(TWIN_GAPS, 20, 22, 1'b0, 1'b1);
		add_request(TWIN_GAPS, 20, 22, 1'b1, 1'b1);
		add_request(TWIN_GAPS, 1, 5, 1'b1, 1'b0);
		add_request(TWIN_GAPS, 1, 6, 1'b0, 1'b0);
		add_request('0, 0, 5, 1'b0, 1'b0);
		add_request('0, 10, 9, 1'b1, 1'b1);
		add_request('0, 1, 41, 1'b0, 1'b1);
		add_request('1, 63, 63, 1'b1, 1'b1);
		add_request('0, 40, 63, 1'b0, 1'b0);
		add_request('0, 0, 0, 1'b1, 1'b0);
		add_request('0, SLOT_COUNT, SLOT_COUNT, 1'b1, 1'b0);
		add_request(40'hAA_AAAA_AAAA, 1, 1, 1'b0, 1'b0);
		add_request(40'h55_5555_5555, 2, 2, 1'b1, 1'b1);
		add_request(40'h00_0000_01F8, 5, 6, 1'b0, 1'b0);
		add_request(40'h00_0000_01F8, 5, 6, 1'b1, 1'b1);
		add_request(40'hF0_0000_000F, 5, 36, 1'b0, 1'b0);
		add_request('0, 33, 40, 1'b0, 1'b1);
		drain();

		write_min_width(1);
		add_random_requests(PHASE_ITEMS);
		drain();

		write_min_width(40);
		add_random_requests(PHASE_ITEMS);
		hold_asked++;
		drain();

		write_min_width($urandom_range(2, 10));
		add_random_requests(PHASE_ITEMS);
		drain();

		write_min_width(12);
		add_random_requests(PHASE_ITEMS);
		hold_asked++;
		drain();

		write_min_width($urandom_range(13, 39));
		add_random_requests(PHASE_ITEMS);
		drain();

		write_min_width(1);
		add_random_requests(PHASE_ITEMS);
		drain();

		repeat (12) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
